// ===== design/pfm_pkg.sv =====
// ---------------------------------------------------------------------------
// pfm_pkg
// Shared constants, types and state encodings for the period/frequency meter.
// ---------------------------------------------------------------------------
package pfm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int FREQ_WIDTH  = 16;
    localparam int CODE_WIDTH  = 8;
    localparam int TPS_WIDTH   = 16;
    localparam int BIN_WIDTH   = 7;   // bits needed for 0..99
    localparam int DIV_CNT_W   = $clog2(FREQ_WIDTH);
    localparam int BCD_CNT_W   = $clog2(BIN_WIDTH);

    localparam logic [TPS_WIDTH-1:0]   TPS_RESET   = TPS_WIDTH'(10000);
    localparam logic [FREQ_WIDTH-1:0]  DISPLAY_MAX = FREQ_WIDTH'(99);
    localparam logic [CODE_WIDTH-1:0]  ERROR_CODE  = 8'hEE;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        PH_WAIT_HIGH,
        PH_WAIT_LOW,
        PH_CNT_LOW,
        PH_CNT_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        BCD_IDLE,
        BCD_RUN,
        BCD_HOLD
    } bcd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic busy;
        logic valid;
    } bcd_status_t;

endpackage

// ===== design/pfm_if.sv =====
// ---------------------------------------------------------------------------
// pfm_if
// Valid/ready channels: one sample item in, one measurement item out.
// ---------------------------------------------------------------------------
interface pfm_sample_if;
    logic valid;
    logic ready;
    logic signal_level;

    modport source (output valid, output signal_level, input ready);
    modport sink   (input valid, input signal_level, output ready);
endinterface

interface pfm_result_if
    import pfm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [FREQ_WIDTH-1:0] frequency_hz;
    logic [CODE_WIDTH-1:0] display_code;
    logic                  over_range;

    modport source (output valid, output frequency_hz, output display_code,
                    output over_range, input ready);
    modport sink   (input valid, input frequency_hz, input display_code,
                    input over_range, output ready);
endinterface

// ===== design/pfm_div.sv =====
// ---------------------------------------------------------------------------
// pfm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pfm_div
    import pfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [FREQ_WIDTH-1:0]  dividend,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output div_status_t            status,
    output logic [FREQ_WIDTH-1:0]  quotient
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [FREQ_WIDTH-1:0]  quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   q_bit;

    // dividend bits shift out of the top of quo_reg as quotient bits enter below
    assign trial = {rem_reg, quo_reg[FREQ_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign q_bit = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = q_bit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_next  = {quo_reg[FREQ_WIDTH-2:0], q_bit};
            step_next = step_reg + DIV_CNT_W'(1);
            if (step_reg == DIV_CNT_W'(FREQ_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== design/pfm_bcd.sv =====
// ---------------------------------------------------------------------------
// pfm_bcd
// Serial double-dabble to two BCD digits, error code above 99.
// ---------------------------------------------------------------------------
module pfm_bcd
    import pfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FREQ_WIDTH-1:0] value,
    input  logic                  take,
    output bcd_status_t           status,
    output logic [CODE_WIDTH-1:0] code,
    output logic                  over
);

    bcd_state_t             state_reg, state_next;
    logic [BCD_CNT_W-1:0]   step_reg;
    logic [BIN_WIDTH-1:0]   bin_reg;
    logic [CODE_WIDTH-1:0]  code_reg;
    logic                   over_reg;
    logic                   too_big;
    logic                   last_step;
    logic [CODE_WIDTH-1:0]  adjusted;

    function automatic logic [3:0] dabble(input logic [3:0] d);
        dabble = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

    assign too_big   = (value > DISPLAY_MAX);
    assign last_step = (step_reg == BCD_CNT_W'(BIN_WIDTH - 1));
    assign adjusted  = {dabble(code_reg[7:4]), dabble(code_reg[3:0])};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BCD_IDLE:
            begin
                if (start)
                    state_next = too_big ? BCD_HOLD : BCD_RUN;
            end
            BCD_RUN:
            begin
                if (last_step)
                    state_next = BCD_HOLD;
            end
            BCD_HOLD:
            begin
                if (take)
                    state_next = BCD_IDLE;
            end
            default: state_next = BCD_IDLE;
        endcase
    end

    always_comb
    begin
        status.busy  = 1'b0;
        status.valid = 1'b0;
        unique case (state_reg)
            BCD_IDLE: ;
            BCD_RUN:  status.busy = 1'b1;
            BCD_HOLD:
            begin
                status.busy  = 1'b1;
                status.valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BCD_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BCD_RUN)
                step_reg <= step_reg + BCD_CNT_W'(1);
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BCD_IDLE && start)
        begin
            bin_reg  <= value[BIN_WIDTH-1:0];
            code_reg <= too_big ? ERROR_CODE : '0;
            over_reg <= too_big;
        end
        else if (state_reg == BCD_RUN)
        begin
            // add-3 correction, then shift in the next binary bit
            code_reg <= {adjusted[CODE_WIDTH-2:0], bin_reg[BIN_WIDTH-1]};
            bin_reg  <= {bin_reg[BIN_WIDTH-2:0], 1'b0};
        end
    end

    assign code = code_reg;
    assign over = over_reg;

endmodule

// ===== design/period_frequency_meter_bcd.sv =====
// ---------------------------------------------------------------------------
// period_frequency_meter_bcd
// Reciprocal frequency meter with two-digit BCD display code.
// ---------------------------------------------------------------------------
// Each sample item is one time-base tick. Items that do not close a period are
// taken one per cycle when the divider and BCD stage are idle. The falling
// edge that closes a period starts a serial divide, ticks_per_second / tick
// count, one quotient bit per cycle, then a serial binary-to-BCD pass (skipped
// when the value is above 99); the result item then goes to the output
// register. Samples are stalled while the divider or the BCD stage holds work;
// the output register lets the next period start while a result waits to be
// taken. ticks_per_second may be written only while no period result is in
// flight.
// ---------------------------------------------------------------------------
module period_frequency_meter_bcd
    import pfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TPS_WIDTH-1:0] cfg_wdata,
    pfm_sample_if.sink           samples,
    pfm_result_if.source         results
);

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_count_reg, count_next;
    logic [TPS_WIDTH-1:0]   tps_reg;
    logic                   period_end;
    logic                   accept;
    logic [COUNT_WIDTH-1:0] count_inc;

    div_status_t            div_st;
    bcd_status_t            bcd_st;
    logic [FREQ_WIDTH-1:0]  quotient;
    logic [CODE_WIDTH-1:0]  bcd_code;
    logic                   bcd_over;
    logic                   load;

    logic                   out_valid_reg;
    logic [FREQ_WIDTH-1:0]  freq_reg;
    logic [CODE_WIDTH-1:0]  code_reg;
    logic                   over_reg;

    assign samples.ready = !div_st.busy && !bcd_st.busy;
    assign accept        = samples.valid && samples.ready;
    assign count_inc     = (tick_count_reg == COUNT_MAX) ? tick_count_reg
                                                         : tick_count_reg + COUNT_WIDTH'(1);

    // phase sequencer: next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_WAIT_HIGH: if (samples.signal_level)  phase_next = PH_WAIT_LOW;
            PH_WAIT_LOW:  if (!samples.signal_level) phase_next = PH_CNT_LOW;
            PH_CNT_LOW:   if (samples.signal_level)  phase_next = PH_CNT_HIGH;
            PH_CNT_HIGH:  if (!samples.signal_level) phase_next = PH_WAIT_HIGH;
            default:      phase_next = PH_WAIT_HIGH;
        endcase
    end

    // phase sequencer: outputs
    always_comb
    begin
        count_next = tick_count_reg;
        period_end = 1'b0;
        unique case (phase_reg)
            PH_WAIT_HIGH: ;
            PH_WAIT_LOW:
            begin
                if (!samples.signal_level)
                    count_next = COUNT_WIDTH'(1);
            end
            PH_CNT_LOW:   count_next = count_inc;
            PH_CNT_HIGH:
            begin
                if (samples.signal_level)
                    count_next = count_inc;
                else
                    period_end = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_HIGH;
            tick_count_reg <= '0;
            tps_reg        <= TPS_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= count_next;
            end
            if (cfg_we)
                tps_reg <= cfg_wdata;
        end
    end

    pfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && period_end),
        .dividend (tps_reg),
        .divisor  (tick_count_reg),
        .status   (div_st),
        .quotient (quotient)
    );

    pfm_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_st.done),
        .value  (quotient),
        .take   (load),
        .status (bcd_st),
        .code   (bcd_code),
        .over   (bcd_over)
    );

    // quotient stays put until the BCD stage releases its item
    assign load = bcd_st.valid && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            freq_reg <= quotient;
            code_reg <= bcd_code;
            over_reg <= bcd_over;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.frequency_hz = freq_reg;
    assign results.display_code = code_reg;
    assign results.over_range   = over_reg;

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_CNT_HIGH && !samples.signal_level) |=> div_st.busy)
        else $error("divider not started at end of period");

    a_bcd_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |=> bcd_st.busy)
        else $error("quotient dropped between divider and BCD stage");

    a_count_min: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CNT_HIGH |-> tick_count_reg >= COUNT_WIDTH'(2))
        else $error("period count below two in high phase");

    a_range_code: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.over_range == (results.frequency_hz > DISPLAY_MAX))
                          && (!results.over_range || results.display_code == ERROR_CODE))
        else $error("over-range flag or error code inconsistent with frequency");

endmodule
